// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the rotary position embedding block.
// Depends on nothing; files that assert include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while rst_n is low.
`define RPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check, masked while rst_n is low.
`define RPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/rpe_pkg.sv =====
// Package for the rotary position embedding block: sizes, types, constants.
// Used by every RTL file; depends on nothing.
package rpe_pkg;

  localparam int HEAD_SIZE     = 128;
  localparam int CORDIC_STAGES = 16;
  localparam int USED_STAGES   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int SLOT_COUNT    = HEAD_SIZE / 2;
  localparam int SLOT_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_RECIP    = (1 << 20) / SLOT_COUNT;

  localparam int DW = 36;   // datapath x/y: Q4.11 with 16 extra fraction bits plus growth
  localparam int ZW = 32;   // residual angle, 2^-32 turn

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam logic [31:0] ATAN_TURN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_ROTATE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  pair_index;
    logic [15:0] position;
    logic [31:0] angle_step;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // pair_index modulo SLOT_COUNT: reciprocal estimate, then one correction
  function automatic logic [SLOT_W-1:0] slot_of(input logic [9:0] idx);
    logic [30:0] prod;
    logic [9:0]  q;
    logic [19:0] qm;
    logic [9:0]  r;
    prod = {21'd0, idx} * 31'(SLOT_RECIP);
    q    = prod[29:20];
    qm   = 20'(q) * 20'(SLOT_COUNT);
    r    = idx - qm[9:0];
    if (r >= 10'(SLOT_COUNT)) begin
      r = r - 10'(SLOT_COUNT);
    end
    return r[SLOT_W-1:0];
  endfunction

endpackage

// ===== design/rpe_front.sv =====
// Front end: input register, step table, angle multiply, quarter-turn pre-rotation.
// Depends on rpe_pkg.
module rpe_front import rpe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rotate_inverse,
  input  logic    in_valid,
  output logic    in_ready,
  input  req_t    in_req,
  output logic    out_valid,
  input  logic    out_ready,
  output cordic_t out_data
);

  // stage A: registered request
  logic a_valid_r;
  req_t a_req_r;
  // stage B: step read back from the table
  logic               b_valid_r;
  logic [15:0]        b_pos_r;
  logic [31:0]        step_rd_r;
  logic signed [15:0] b_va_r, b_vb_r;
  // stage C: angle
  logic               c_valid_r;
  logic [31:0]        c_angle_r;
  logic signed [15:0] c_va_r, c_vb_r;
  // stage D: CORDIC entry
  logic    d_valid_r;
  cordic_t d_data_r;

  logic [31:0] step_mem [SLOT_COUNT];

  logic              b_ready, c_ready, d_ready, a_fire;
  logic [SLOT_W-1:0] slot;
  logic [47:0]       angle_full;
  logic [31:0]       ang, ang_off, u;
  logic [1:0]        quad;
  logic signed [DW-1:0] av, bv;
  cordic_t           d_data_nxt;

  assign d_ready  = !d_valid_r || out_ready;
  assign c_ready  = !c_valid_r || d_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign in_ready = !a_valid_r || b_ready;
  assign a_fire   = a_valid_r && b_ready;
  assign slot     = slot_of(a_req_r.pair_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_req_r <= in_req;
    end
  end

  // step table: write on a load leaving stage A, registered read on a rotate
  always_ff @(posedge clk) begin
    if (a_fire && a_req_r.cmd == CMD_LOAD) begin
      step_mem[slot] <= a_req_r.angle_step;
    end
    if (a_fire && a_req_r.cmd == CMD_ROTATE) begin
      step_rd_r <= step_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r && a_req_r.cmd == CMD_ROTATE;
    end
    if (a_fire) begin
      b_pos_r <= a_req_r.position;
      b_va_r  <= a_req_r.value_a;
      b_vb_r  <= a_req_r.value_b;
    end
  end

  assign angle_full = {32'd0, b_pos_r} * {16'd0, step_rd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
    if (c_ready && b_valid_r) begin
      c_angle_r <= angle_full[31:0];
      c_va_r    <= b_va_r;
      c_vb_r    <= b_vb_r;
    end
  end

  // quadrant split leaves a residual in [-1/8, 1/8) turn
  always_comb begin
    ang     = rotate_inverse ? (32'd0 - c_angle_r) : c_angle_r;
    ang_off = ang + 32'h2000_0000;
    quad    = ang_off[31:30];
    u       = ang - {quad, 30'd0};
    av      = {{(DW-32){c_va_r[15]}}, c_va_r, 16'd0};
    bv      = {{(DW-32){c_vb_r[15]}}, c_vb_r, 16'd0};
    d_data_nxt.z = $signed(u);
    case (quad)
      2'd0: begin
        d_data_nxt.x = av;
        d_data_nxt.y = bv;
      end
      2'd1: begin
        d_data_nxt.x = -bv;
        d_data_nxt.y = av;
      end
      2'd2: begin
        d_data_nxt.x = -av;
        d_data_nxt.y = -bv;
      end
      default: begin
        d_data_nxt.x = bv;
        d_data_nxt.y = -av;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= c_valid_r;
    end
    if (d_ready && c_valid_r) begin
      d_data_r <= d_data_nxt;
    end
  end

  assign out_valid = d_valid_r;
  assign out_data  = d_data_r;

endmodule

// ===== design/rpe_cell.sv =====
// One CORDIC micro-rotation cell with its own valid/ready stage register.
// Depends on rpe_pkg.
module rpe_cell import rpe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] stage_idx,   // tied to the cell's place in the row
  input  logic       in_valid,
  output logic       in_ready,
  input  cordic_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cordic_t    out_data
);

  logic    valid_r;
  cordic_t data_r, data_nxt;
  logic signed [DW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    dx = in_data.y >>> stage_idx;
    dy = in_data.x >>> stage_idx;
    at = $signed(ATAN_TURN[stage_idx]);
    if (!in_data.z[ZW-1]) begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - at;
    end else begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/rpe_finish.sv =====
// Gain compensation, rounding and saturation, ending in the output register.
// Depends on rpe_pkg. Multiply split into two 18-bit partial products.
module rpe_finish import rpe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cordic_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_a,
  output logic signed [15:0] out_b
);

  localparam int LO_W = 18;
  localparam int HI_W = DW - LO_W;
  localparam int PH_W = HI_W + 31;
  localparam int PL_W = LO_W + 30;
  localparam int SW   = DW + 32;
  localparam logic signed [SW-1:0] RND = SW'(1) << 45;

  logic                   p_valid_r, o_valid_r;
  logic signed [PH_W-1:0] phx_r, phy_r;
  logic [PL_W-1:0]        plx_r, ply_r;
  logic signed [15:0]     oa_r, ob_r;
  logic                   p_ready, o_ready;

  function automatic logic signed [PH_W-1:0] hi_prod(input logic signed [DW-1:0] v);
    logic signed [HI_W-1:0] h;
    h = v[DW-1:LO_W];
    return PH_W'(h) * PH_W'($signed({1'b0, GAIN_Q30}));
  endfunction

  function automatic logic [PL_W-1:0] lo_prod(input logic signed [DW-1:0] v);
    logic [LO_W-1:0] l;
    l = v[LO_W-1:0];
    return PL_W'(l) * PL_W'(GAIN_Q30);
  endfunction

  // sum partials, round half up at bit 46, clamp to 16 bits
  function automatic logic signed [15:0] round_sat(input logic signed [PH_W-1:0] ph,
                                                   input logic [PL_W-1:0] pl);
    logic signed [SW-1:0]    total;
    logic signed [SW-47:0]   r;
    logic signed [15:0]      res;
    total = (SW'(ph) <<< LO_W) + $signed(SW'(pl)) + RND;
    r     = total[SW-1:46];
    if (r > (SW-46)'(32767)) begin
      res = 16'sh7FFF;
    end else if (r < -(SW-46)'(32768)) begin
      res = -16'sh8000;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

  assign o_ready  = !o_valid_r || out_ready;
  assign p_ready  = !p_valid_r || o_ready;
  assign in_ready = p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_ready) begin
      p_valid_r <= in_valid;
    end
    if (p_ready && in_valid) begin
      phx_r <= hi_prod(in_data.x);
      plx_r <= lo_prod(in_data.x);
      phy_r <= hi_prod(in_data.y);
      ply_r <= lo_prod(in_data.y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_ready) begin
      o_valid_r <= p_valid_r;
    end
    if (o_ready && p_valid_r) begin
      oa_r <= round_sat(phx_r, plx_r);
      ob_r <= round_sat(phy_r, ply_r);
    end
  end

  assign out_valid = o_valid_r;
  assign out_a     = oa_r;
  assign out_b     = ob_r;

endmodule

// ===== design/rotary_position_embed_rotate.sv =====
// Rotary position embedding, one element pair per item.
// Input stream: in_tuser selects the command (load a slot's angle step, or
// rotate a pair); in_tdata carries pair index, position, step and the pair.
// A load writes the step table (slot = pair_index mod HEAD_SIZE/2) and gives
// no result item; a rotate gives exactly one result item on the out_ stream.
// cfg_we/cfg_wdata set rotate_inverse; write it only while the block is idle.
// Throughput: one item per cycle, back to back, loads and rotates mixed,
// as long as the result stream does not stall. A rotate passes through the
// input register, table read, angle multiply, quarter-turn split, one cell
// per micro-rotation, partial products of the gain multiply, then the
// output register.
// Every stage has its own valid bit and takes a new item whenever it is
// empty or its successor moves, so bubbles close up. When the receiver
// stalls, items pile up behind the output register and in_tready falls only
// once every stage is full.
// Reset clears all valid bits and rotate_inverse; the step table keeps no
// reset value, and a rotate of a never-loaded slot is undefined.
`include "assert_macros.svh"
module rotary_position_embed_rotate import rpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // pair_index[9:0], position[25:10], angle_step[57:26],
                                  // value_a[73:58], value_b[89:74], zeros above
  input  logic [0:0]  in_tuser,   // command: 0 load, 1 rotate
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // rotated_a[15:0], rotated_b[31:16]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata   // rotate_inverse
);

  logic rotate_inverse_r;
  req_t in_req;

  // cell row handshake: index 0 is the front end, USED_STAGES the last cell
  logic    cv [USED_STAGES+1];
  logic    cr [USED_STAGES+1];
  cordic_t cd [USED_STAGES+1];

  logic signed [15:0] rot_a, rot_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotate_inverse_r <= 1'b0;
    end else if (cfg_we) begin
      rotate_inverse_r <= cfg_wdata;
    end
  end

  // unpack the item
  assign in_req.cmd        = cmd_t'(in_tuser[0]);
  assign in_req.pair_index = in_tdata[9:0];
  assign in_req.position   = in_tdata[25:10];
  assign in_req.angle_step = in_tdata[57:26];
  assign in_req.value_a    = $signed(in_tdata[73:58]);
  assign in_req.value_b    = $signed(in_tdata[89:74]);

  rpe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .rotate_inverse (rotate_inverse_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_req         (in_req),
    .out_valid      (cv[0]),
    .out_ready      (cr[0]),
    .out_data       (cd[0])
  );

  // one cell per micro-rotation, each shifting by its own place in the row
  for (genvar i = 0; i < USED_STAGES; i++) begin : g_cell
    rpe_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (5'(i)),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  rpe_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv[USED_STAGES]),
    .in_ready  (cr[USED_STAGES]),
    .in_data   (cd[USED_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_a     (rot_a),
    .out_b     (rot_b)
  );

  assign out_tdata = {rot_b, rot_a};

  // back-pressure only ever starts at a stalled output
  `RPE_ASSERT_IMP(a_stall_origin, !in_tready, out_tvalid && !out_tready,
                  "input stalled without a stalled result")
  // residual angle entering the row stays within an eighth of a turn
  `RPE_ASSERT_IMP(a_residual_range, cv[0],
                  cd[0].z[ZW-1:ZW-3] == 3'b000 || cd[0].z[ZW-1:ZW-3] == 3'b111,
                  "CORDIC residual angle out of range")

endmodule

// ===== tb/tb_rotary_position_embed_rotate.sv =====
// Self-checking testbench for rotary_position_embed_rotate: step-table loads and pair rotations.
// Depends on rpe_pkg (command codes, table size, stage count, arctangent table, gain constant).
`timescale 1ns / 1ps
module tb_rotary_position_embed_rotate;
  import rpe_pkg::*;

  // Quiet-cycle limit: far above pipeline latency + longest sender gap + longest stall.
  localparam int unsigned QUIET_LIMIT = 4000;
  // Gain compensation constant, widened for the 64-bit rounding product.
  localparam longint GAIN_K = longint'(GAIN_Q30);

  // Receiver behaviour on the result stream.
  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC
  } ready_mode_t;

  // One result item as the block presents it.
  typedef struct packed {
    logic signed [15:0] rotated_b;
    logic signed [15:0] rotated_a;
  } rotated_pair_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;   // pair_index, position, angle_step, value_a, value_b
  logic [0:0]  in_tuser   = '0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // rotated_a, rotated_b
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0; // rotate_inverse

  // Predictor state: our own copy of the step table and the inverse flag.
  logic [31:0]   angle_steps [SLOT_COUNT];
  bit            slot_loaded [SLOT_COUNT];
  logic          inverse_setting = 1'b0;
  rotated_pair_t pending_rotations [$];

  int          fail_count   = 0;
  int          burst_left   = 1;
  bit          sender_gaps  = 1'b1;
  ready_mode_t ready_mode   = READY_ALWAYS;
  int unsigned ready_phase  = 0;
  int unsigned quiet_cycles = 0;

  rotary_position_embed_rotate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Gain compensation (Q1.30), round half up from 46 fraction bits, clamp to 16 bits.
  function automatic logic signed [15:0] compensate_and_clamp(longint acc);
    longint r;
    r = (acc * GAIN_K + (longint'(1) <<< 45)) >>> 46;
    if (r > 32767) begin
      return 16'sh7FFF;
    end
    if (r < -32768) begin
      return 16'sh8000;
    end
    return 16'(r);
  endfunction

  // Angle = position * step mod one turn (negated for inverse), exact quarter-turn
  // pre-rotation, then micro-rotations on the residual angle with 16 extra fraction bits.
  function automatic rotated_pair_t rotate_pair(logic [15:0] pos, logic [31:0] step,
                                                logic inv, logic signed [15:0] va,
                                                logic signed [15:0] vb);
    logic [47:0]   prod;
    logic [31:0]   angle;
    logic [31:0]   shifted;
    logic [31:0]   resid;
    logic [1:0]    quadrant;
    longint        a, b, x, y, z, nx, dx, dy;
    rotated_pair_t r;
    prod  = pos * step;
    angle = prod[31:0];
    if (inv) begin
      angle = -angle;
    end
    // nearest quarter turn; residual lands in [-1/8, 1/8) turn
    shifted  = angle + 32'h2000_0000;
    quadrant = shifted[31:30];
    resid    = angle - {quadrant, 30'd0};
    z = longint'(signed'(resid));
    a = longint'(va) * 65536;
    b = longint'(vb) * 65536;
    case (quadrant)
      2'd0: begin x = a;  y = b;  end
      2'd1: begin x = -b; y = a;  end
      2'd2: begin x = -a; y = -b; end
      default: begin x = b; y = -a; end
    endcase
    for (int i = 0; i < USED_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        nx = x - dx;
        y  = y + dy;
        z  = z - longint'(ATAN_TURN[i]);
      end else begin
        nx = x + dx;
        y  = y - dy;
        z  = z + longint'(ATAN_TURN[i]);
      end
      x = nx;
    end
    r.rotated_a = compensate_and_clamp(x);
    r.rotated_b = compensate_and_clamp(y);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver stalls and checks each accepted result item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rotated_pair_t want;
    logic signed [15:0] got_a;
    logic signed [15:0] got_b;
    if (rst_n && out_tvalid && out_tready) begin
      got_a = out_tdata[15:0];
      got_b = out_tdata[31:16];
      if (pending_rotations.size() == 0) begin
        $display("%0t unexpected result item: actual rotated_a %0d rotated_b %0d",
                 $time, got_a, got_b);
        fail_count++;
      end else begin
        want = pending_rotations.pop_front();
        if (got_a !== want.rotated_a) begin
          $display("%0t rotated_a mismatch: expected %0d actual %0d",
                   $time, want.rotated_a, got_a);
          fail_count++;
        end
        if (got_b !== want.rotated_b) begin
          $display("%0t rotated_b mismatch: expected %0d actual %0d",
                   $time, want.rotated_b, got_b);
          fail_count++;
        end
      end
    end
    // stall pattern, independent of the sender's bursts
    case (ready_mode)
      READY_ALWAYS:  out_tready <= 1'b1;
      READY_RANDOM:  out_tready <= ($urandom_range(0, 99) < 60);
      default:       out_tready <= ((ready_phase % 13) < 8);
    endcase
    ready_phase++;
  end

  // Watchdog: ends the run once nothing has moved on either stream for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t timeout: no item moved for %0d cycles", $time, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until accepted; the prediction is made at the accepting
  // edge. In gappy mode valid drops for a random gap at the end of each random burst.
  task automatic send_item(cmd_t cmd, logic [9:0] pair, logic [15:0] pos, logic [31:0] step,
                           logic signed [15:0] va, logic signed [15:0] vb);
    int            slot;
    rotated_pair_t predicted;
    slot = int'(pair) % SLOT_COUNT;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, vb, va, step, pos, pair};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    if (cmd == CMD_LOAD) begin
      angle_steps[slot] = step;
      slot_loaded[slot] = 1'b1;
    end else begin
      predicted = rotate_pair(pos, angle_steps[slot], inverse_setting, va, vb);
      pending_rotations.insert(pending_rotations.size(), predicted);
    end
    if (sender_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Waits for every outstanding result, then for any load still in the pipe.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pending_rotations.size() != 0) begin
      @(posedge clk);
    end
    repeat (USED_STAGES + 10) @(posedge clk);
  endtask

  task automatic write_inverse(logic inv);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_we <= 1'b0;
    inverse_setting = inv;
  endtask

  // Mostly full-range values, with the extremes and the values near zero now and then.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 2)) - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rotations over the loaded directed slots: zero angle, exact quarter, half and
  // three-quarter turns, the 1/8-turn residual boundary, full-scale steps and positions,
  // and value extremes that saturate. The angle_step field is junk and must be ignored.
  task automatic send_extreme_rotations();
    send_item(CMD_ROTATE, 10'd0,    16'h0000, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000);
    send_item(CMD_ROTATE, 10'd64,   16'hFFFF, 32'hFFFF_FFFF, 16'sh8000, 16'sh8000);
    send_item(CMD_ROTATE, 10'd1,    16'h0001, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF);
    send_item(CMD_ROTATE, 10'd1,    16'h0002, 32'hFFFF_FFFF, 16'sh8000, 16'sh0000);
    send_item(CMD_ROTATE, 10'd1,    16'h0003, 32'hFFFF_FFFF, 16'sh8000, 16'sh8000);
    send_item(CMD_ROTATE, 10'd2,    16'hFFFF, 32'h0000_0000, 16'sh1234, -16'sh0001);
    send_item(CMD_ROTATE, 10'd3,    16'h0001, 32'h0000_0000, 16'sh0000, 16'sh8000);
    send_item(CMD_ROTATE, 10'd1023, 16'h0001, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF);
    send_item(CMD_ROTATE, 10'd1023, 16'h0003, 32'hFFFF_FFFF, 16'sh8000, 16'sh7FFF);
    send_item(CMD_ROTATE, 10'd4,    16'h0001, 32'h5555_5555, 16'sh7FFF, 16'sh8000);
    send_item(CMD_ROTATE, 10'd961,  16'hFFFF, 32'hFFFF_FFFF, 16'sh3039, -16'sh1A85);
  endtask

  // Loads carry junk in position and values, which must be ignored.
  task automatic test_extreme_steps();
    sender_gaps = 1'b0;
    ready_mode  = READY_ALWAYS;
    send_item(CMD_LOAD, 10'd0,    16'hFFFF, 32'h0000_0000, 16'sh7FFF, 16'sh8000);
    send_item(CMD_LOAD, 10'd1,    16'h0000, 32'h4000_0000, 16'sh8000, 16'sh7FFF);
    send_item(CMD_LOAD, 10'd2,    16'hFFFF, 32'hFFFF_FFFF, -16'sh0001, -16'sh0001);
    send_item(CMD_LOAD, 10'd3,    16'hA5A5, 32'h8000_0000, 16'sh5A5A, 16'sh0000);
    send_item(CMD_LOAD, 10'd1023, 16'h5A5A, 32'h2000_0000, 16'sh0000, 16'sh5A5A);
    send_item(CMD_LOAD, 10'd4,    16'h0000, 32'h1FFF_FFFF, 16'sh0001, 16'sh7FFF);
    send_extreme_rotations();
  endtask

  task automatic test_inverse_extremes();
    write_inverse(1'b1);
    sender_gaps = 1'b1;
    ready_mode  = READY_PERIODIC;
    send_extreme_rotations();
  endtask

  // Random mix: about a quarter loads to any pair index, the rest rotations of slots
  // already loaded, reached through any pair index that maps onto them.
  task automatic test_random_traffic(int count, logic inv, ready_mode_t mode, bit gappy);
    int          slot;
    logic [9:0]  pair;
    logic [15:0] pos;
    logic [31:0] step;
    write_inverse(inv);
    sender_gaps = gappy;
    ready_mode  = mode;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        pair = 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 4))
          0: step = 32'($urandom_range(0, 255));
          1: step = 32'h1 << $urandom_range(0, 31);
          2: step = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
          default: step = $urandom();
        endcase
        send_item(CMD_LOAD, pair, 16'($urandom()), step, 16'($urandom()), 16'($urandom()));
      end else begin
        do begin
          slot = $urandom_range(0, SLOT_COUNT - 1);
        end while (!slot_loaded[slot]);
        pair = 10'(slot + SLOT_COUNT * $urandom_range(0, (1023 - slot) / SLOT_COUNT));
        pos  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom());
        send_item(CMD_ROTATE, pair, pos, $urandom(), pick_value(), pick_value());
      end
    end
  endtask

  // Realistic use: per-slot frequencies for base 500000, then rotations at
  // sequence positions.
  task automatic test_rope_frequencies();
    real  freq;
    int   slot;
    write_inverse(1'b0);
    sender_gaps = 1'b1;
    ready_mode  = READY_RANDOM;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      // one turn / (2 pi) per radian, scaled by base^(-2s/head)
      freq = 683565275.5764 * (500000.0 ** (-2.0 * s / HEAD_SIZE));
      send_item(CMD_LOAD, 10'(s + SLOT_COUNT * $urandom_range(0, (1023 - s) / SLOT_COUNT)),
                16'($urandom()), 32'($rtoi(freq + 0.5)), 16'($urandom()), 16'($urandom()));
    end
    for (int n = 0; n < 100; n++) begin
      slot = $urandom_range(0, SLOT_COUNT - 1);
      send_item(CMD_ROTATE, 10'(slot), 16'($urandom_range(0, 8191)), $urandom(),
                pick_value(), pick_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_inverse(1'b0);
    test_extreme_steps();
    test_inverse_extremes();
    test_random_traffic(450, 1'b1, READY_RANDOM,   1'b1);
    test_random_traffic(450, 1'b0, READY_PERIODIC, 1'b1);
    test_random_traffic(450, 1'b1, READY_ALWAYS,   1'b0);
    test_rope_frequencies();

    drain_block();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
